>>> rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int IDX_W      = 11;
   localparam int CELL_BITS  = 16;

   localparam logic [CELL_BITS-1:0] BLANK_CELL = 16'h0F20;

   localparam logic [7:0] CHAR_NUL       = 8'd0;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [3:0] BG_BLACK = 4'h0;

   typedef struct packed {
      logic [COL_W-1:0]     cursor_col;
      logic [ROW_W-1:0]     cursor_row;
      logic                 cell_written;
      logic [IDX_W-1:0]     cell_index;
      logic [CELL_BITS-1:0] cell_value;
      logic                 scrolled;
   } rsp_type;

   function automatic logic [3:0] fg_of(input logic [23:0] rgb);
      logic [3:0] fg;
      case (rgb)
         24'h00C2A8: fg = 4'd10;
         24'h6C63FF: fg = 4'd9;
         24'hFF6B6B: fg = 4'd12;
         24'hFFFF00: fg = 4'd14;
         24'hF5A623: fg = 4'd14;
         24'h888888: fg = 4'd8;
         24'h00FFFF: fg = 4'd11;
         default:    fg = 4'd15;
      endcase
      return fg;
   endfunction

endpackage

>>> rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// The result beat is registered at acceptance, or held in a pending register while
// rsp_stall holds the output. Printed characters, newlines and backspaces that do
// not scroll let the next request in unless a beat is pending; a scroll or a clear
// stalls requests for a sweep over the cell memory, one cell per cycle through its single write port.
// Reset: cursor homes, then a clearing pass blanks every cell of the memory.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [7:0]           req_char_code,
   input  logic [23:0]          req_color_rgb,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COL_W-1:0]     rsp_cursor_col,
   output logic [ROW_W-1:0]     rsp_cursor_row,
   output logic                 rsp_cell_written,
   output logic [IDX_W-1:0]     rsp_cell_index,
   output logic [CELL_BITS-1:0] rsp_cell_value,
   output logic                 rsp_scrolled
);

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   state_type            state_ff;
   logic [CELL_W-1:0]    sweep_ptr_ff;
   logic                 copy_ff;
   logic [COL_W-1:0]     col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 wr_act_ff;
   logic                 wr_copy_ff;
   logic [CELL_W-1:0]    wr_ptr_ff;
   logic [CELL_BITS-1:0] rd_data_ff;
   logic                 out_valid_ff;
   logic                 pend_valid_ff;
   rsp_type              out_ff;
   rsp_type              pend_ff;

   logic [CELL_BITS-1:0] mem [CELL_COUNT];

   logic                 accept;
   logic                 out_free;
   logic [3:0]           fg;
   logic [CELL_W-1:0]    cur_idx;
   logic [COL_W-1:0]     col_in;
   logic [ROW_W-1:0]     row_in;
   logic                 scroll_in;
   logic                 clear_in;
   rsp_type              rsp_in;
   logic                 copy_region;
   logic                 rd_en;
   logic [CELL_W-1:0]    rd_addr;
   logic                 item_we;
   logic                 mem_we;
   logic [CELL_W-1:0]    mem_waddr;
   logic [CELL_BITS-1:0] mem_wdata;

   assign req_stall = (state_ff != ST_IDLE) || wr_act_ff || pend_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      fg        = fg_of(req_color_rgb);
      cur_idx   = CELL_W'(row_ff) * CELL_W'(COLUMNS) + CELL_W'(col_ff);
      col_in    = col_ff;
      row_in    = row_ff;
      scroll_in = 1'b0;
      clear_in  = 1'b0;
      rsp_in    = '0;
      if (req_opcode == OP_CLEAR) begin
         col_in   = '0;
         row_in   = '0;
         clear_in = 1'b1;
      end else begin
         case (req_char_code)
            CHAR_NEWLINE: begin
               col_in = '0;
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  scroll_in = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
            CHAR_BACKSPACE: begin
               if (col_ff != '0) begin
                  col_in              = col_ff - 1'b1;
                  rsp_in.cell_written = 1'b1;
                  rsp_in.cell_index   = IDX_W'(cur_idx - 1'b1);
                  rsp_in.cell_value   = {BG_BLACK, fg, CHAR_SPACE};
               end
            end
            CHAR_NUL: begin
            end
            default: begin
               rsp_in.cell_written = 1'b1;
               rsp_in.cell_index   = IDX_W'(cur_idx);
               rsp_in.cell_value   = {BG_BLACK, fg, req_char_code};
               if (col_ff == COL_W'(COLUMNS - 1)) begin
                  col_in = '0;
                  if (row_ff == ROW_W'(ROWS - 1)) begin
                     scroll_in = 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         endcase
      end
      rsp_in.cursor_col = col_in;
      rsp_in.cursor_row = row_in;
      rsp_in.scrolled   = scroll_in;
   end

   // sweep: read the cell one row below, write it back in the next cycle
   assign copy_region = copy_ff && (sweep_ptr_ff < CELL_W'(COPY_CELLS));
   assign rd_en       = (state_ff == ST_SWEEP) && copy_region;
   assign rd_addr     = sweep_ptr_ff + CELL_W'(COLUMNS);
   assign item_we     = accept && rsp_in.cell_written;

   always_comb begin
      mem_we    = wr_act_ff || item_we;
      mem_waddr = wr_act_ff ? wr_ptr_ff : CELL_W'(rsp_in.cell_index);
      mem_wdata = wr_act_ff ? (wr_copy_ff ? rd_data_ff : BLANK_CELL) : rsp_in.cell_value;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ptr_ff  <= '0;
         copy_ff       <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         wr_act_ff     <= 1'b0;
         wr_copy_ff    <= 1'b0;
         wr_ptr_ff     <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         wr_act_ff  <= (state_ff == ST_SWEEP);
         wr_copy_ff <= copy_region;
         wr_ptr_ff  <= sweep_ptr_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (scroll_in || clear_in)) begin
                  state_ff     <= ST_SWEEP;
                  sweep_ptr_ff <= '0;
                  copy_ff      <= scroll_in;
               end
            end
            ST_SWEEP: begin
               sweep_ptr_ff <= sweep_ptr_ff + 1'b1;
               if (sweep_ptr_ff == CELL_W'(CELL_COUNT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            if (out_free) begin
               out_ff       <= rsp_in;
               out_valid_ff <= 1'b1;
            end else begin
               pend_ff       <= rsp_in;
               pend_valid_ff <= 1'b1;
            end
         end else if (out_free) begin
            if (pend_valid_ff) begin
               out_ff        <= pend_ff;
               out_valid_ff  <= 1'b1;
               pend_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cursor_col   = out_ff.cursor_col;
   assign rsp_cursor_row   = out_ff.cursor_row;
   assign rsp_cell_written = out_ff.cell_written;
   assign rsp_cell_index   = out_ff.cell_index;
   assign rsp_cell_value   = out_ff.cell_value;
   assign rsp_scrolled     = out_ff.scrolled;

`ifndef SYNTH
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> req_stall)
      else $error("beat accepted during sweep");

   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("pending beat without output beat");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLUMNS)) && (row_ff < ROW_W'(ROWS)))
      else $error("cursor out of range");

   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(item_we && wr_act_ff))
      else $error("write port collision");

   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (scroll_in || clear_in)) |=> (state_ff == ST_SWEEP) && (sweep_ptr_ff == '0))
      else $error("sweep did not start");
`endif

endmodule

>>> sim/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int STALL_LIMIT = 12000;
   localparam int QUIET_TAIL  = 200;

   typedef struct {
      logic        opcode;
      logic [7:0]  char_code;
      logic [23:0] color_rgb;
      bit          hold;
   } console_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_WRITE;
   logic [7:0]           req_char_code = '0;
   logic [23:0]          req_color_rgb = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COL_W-1:0]     rsp_cursor_col;
   logic [ROW_W-1:0]     rsp_cursor_row;
   logic                 rsp_cell_written;
   logic [IDX_W-1:0]     rsp_cell_index;
   logic [CELL_BITS-1:0] rsp_cell_value;
   logic                 rsp_scrolled;

   console_cmd_type      cmd_queue[$];
   rsp_type              expected_beats[$];
   console_cmd_type      cur_cmd;
   logic [15:0]          shadow_cells [CELL_COUNT];
   int                   shadow_col;
   int                   shadow_row;
   int                   fails;
   int                   gap_left;
   int                   stall_left;
   int                   idle_cycles;
   logic                 quiet = 1'b0;

   text_console_writer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_char_code    (req_char_code),
      .req_color_rgb    (req_color_rgb),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cell_written (rsp_cell_written),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_scrolled     (rsp_scrolled)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [3:0] palette_fg(input logic [23:0] rgb);
      case (rgb)
         24'h00C2A8: return 4'd10;
         24'h6C63FF: return 4'd9;
         24'hFF6B6B: return 4'd12;
         24'hFFFF00: return 4'd14;
         24'hF5A623: return 4'd14;
         24'h888888: return 4'd8;
         24'h00FFFF: return 4'd11;
         default:    return 4'd15;
      endcase
   endfunction

   task automatic scroll_shadow();
      for (int i = 0; i < COPY_CELLS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (int i = COPY_CELLS; i < CELL_COUNT; i++) shadow_cells[i] = BLANK_CELL;
      shadow_row = ROWS - 1;
   endtask

   // next console state and the beat it should report
   task automatic advance_console(input console_cmd_type c, output rsp_type e);
      logic [3:0] fg;
      int         idx;
      e  = '0;
      fg = palette_fg(c.color_rgb);
      if (c.opcode == OP_CLEAR) begin
         foreach (shadow_cells[i]) shadow_cells[i] = BLANK_CELL;
         shadow_col = 0;
         shadow_row = 0;
      end else if (c.char_code == CHAR_NEWLINE) begin
         shadow_col = 0;
         shadow_row++;
         if (shadow_row >= ROWS) begin
            scroll_shadow();
            e.scrolled = 1'b1;
         end
      end else if (c.char_code == CHAR_BACKSPACE) begin
         if (shadow_col > 0) begin
            shadow_col--;
            idx = shadow_row * COLUMNS + shadow_col;
            e.cell_written = 1'b1;
            e.cell_index   = idx[IDX_W-1:0];
            e.cell_value   = {BG_BLACK, fg, CHAR_SPACE};
            shadow_cells[idx] = e.cell_value;
         end
      end else if (c.char_code != CHAR_NUL) begin
         idx = shadow_row * COLUMNS + shadow_col;
         e.cell_written = 1'b1;
         e.cell_index   = idx[IDX_W-1:0];
         e.cell_value   = {BG_BLACK, fg, c.char_code};
         shadow_cells[idx] = e.cell_value;
         shadow_col++;
         if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
         end
         if (shadow_row >= ROWS) begin
            scroll_shadow();
            e.scrolled = 1'b1;
         end
      end
      e.cursor_col = shadow_col[COL_W-1:0];
      e.cursor_row = shadow_row[ROW_W-1:0];
   endtask

   task automatic push_cmd(input logic op, input logic [7:0] ch, input logic [23:0] rgb,
                           input bit hold = 1'b0);
      console_cmd_type c;
      c.opcode    = op;
      c.char_code = ch;
      c.color_rgb = rgb;
      c.hold      = hold;
      cmd_queue.push_back(c);
   endtask

   function automatic logic [23:0] pick_color();
      case ($urandom_range(0, 13))
         0:       return 24'h00C2A8;
         1:       return 24'h6C63FF;
         2:       return 24'hFF6B6B;
         3:       return 24'hFFFF00;
         4:       return 24'hF5A623;
         5:       return 24'h888888;
         6:       return 24'h00FFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] pick_glyph();
      logic [7:0] ch;
      do ch = 8'($urandom_range(1, 255));
      while (ch == CHAR_NEWLINE || ch == CHAR_BACKSPACE);
      return ch;
   endfunction

   task automatic compare_field(input string name, input longint exp, input longint act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         fails++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic nxt_valid;
      rsp_type e;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            advance_console(cur_cmd, e);
            expected_beats.push_back(e);
            nxt_valid = 1'b0;
            if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_queue.size() > 0 &&
                         (!cmd_queue[0].hold || expected_beats.size() == 0)) begin
               cur_cmd = cmd_queue.pop_front();
               req_opcode    <= cur_cmd.opcode;
               req_char_code <= cur_cmd.char_code;
               req_color_rgb <= cur_cmd.color_rgb;
               nxt_valid = 1'b1;
            end
         end
         req_valid <= nxt_valid;
         quiet     <= (cmd_queue.size() < QUIET_TAIL);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      logic    nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with no pending expectation");
               fails++;
            end else begin
               e = expected_beats.pop_front();
               compare_field("cursor_col", e.cursor_col, rsp_cursor_col);
               compare_field("cursor_row", e.cursor_row, rsp_cursor_row);
               compare_field("cell_written", e.cell_written, rsp_cell_written);
               compare_field("cell_index", e.cell_index, rsp_cell_index);
               compare_field("cell_value", e.cell_value, rsp_cell_value);
               compare_field("scrolled", e.scrolled, rsp_scrolled);
            end
         end
         nxt_stall = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            nxt_stall  = 1'b1;
         end
         rsp_stall <= nxt_stall;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      int len;
      int r;
      fails      = 0;
      shadow_col = 0;
      shadow_row = 0;
      foreach (shadow_cells[i]) shadow_cells[i] = BLANK_CELL;

      // directed
      push_cmd(OP_CLEAR, 8'hFF, 24'hFFFFFF);
      push_cmd(OP_WRITE, CHAR_NUL, 24'h00C2A8);
      push_cmd(OP_WRITE, CHAR_BACKSPACE, 24'h6C63FF);
      push_cmd(OP_WRITE, 8'h41, 24'h00C2A8);
      push_cmd(OP_WRITE, 8'h42, 24'h6C63FF);
      push_cmd(OP_WRITE, 8'h43, 24'hFF6B6B);
      push_cmd(OP_WRITE, 8'h44, 24'hFFFF00);
      push_cmd(OP_WRITE, 8'h45, 24'hF5A623);
      push_cmd(OP_WRITE, 8'h46, 24'h888888);
      push_cmd(OP_WRITE, 8'h47, 24'h00FFFF);
      push_cmd(OP_WRITE, 8'hFF, 24'h000000);
      push_cmd(OP_WRITE, 8'h01, 24'hFFFFFF);
      push_cmd(OP_WRITE, 8'h80, 24'h123456);
      push_cmd(OP_WRITE, CHAR_BACKSPACE, 24'hFF6B6B);
      push_cmd(OP_WRITE, CHAR_NEWLINE, 24'hFFFFFF);
      push_cmd(OP_WRITE, 8'h7F, 24'h00FFFF);
      push_cmd(OP_WRITE, CHAR_BACKSPACE, 24'h888888);
      push_cmd(OP_WRITE, CHAR_BACKSPACE, 24'h888888);
      push_cmd(OP_WRITE, CHAR_NEWLINE, 24'h000000);
      push_cmd(OP_CLEAR, 8'h00, 24'h000000);
      push_cmd(OP_WRITE, 8'h20, 24'hFFFF00);

      // random: mostly text lines, some newline runs, backspaces, noise, rare clears
      n = 0;
      while (n < 1400) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            push_cmd(OP_CLEAR, 8'($urandom()), 24'($urandom()), (n % 300) < 5);
            n++;
         end else if (r < 8) begin
            len = $urandom_range(1, 6);
            repeat (len) push_cmd(OP_WRITE, CHAR_BACKSPACE, pick_color());
            n += len;
         end else if (r < 12) begin
            len = $urandom_range(1, 4);
            repeat (len) push_cmd(OP_WRITE, 8'($urandom()), 24'($urandom()));
            n += len;
         end else if (r < 16) begin
            len = $urandom_range(5, 30);
            repeat (len) push_cmd(OP_WRITE, CHAR_NEWLINE, pick_color());
            n += len;
         end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 40);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 39) == 0) push_cmd(OP_WRITE, CHAR_NUL, pick_color());
               else push_cmd(OP_WRITE, pick_glyph(), pick_color(), i == 0 && (n % 300) < 10);
            end
            n += len;
            if ($urandom_range(0, 3) != 0) begin
               push_cmd(OP_WRITE, CHAR_NEWLINE, pick_color());
               n++;
            end
         end
      end
      // drain pause right after the directed part
      cmd_queue[21].hold = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() > 0 || req_valid || expected_beats.size() > 0) @(posedge clock);
      repeat (CELL_COUNT + 16) @(posedge clock);

      if (fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
